// ===== rtl/core/farg_pkg.sv =====
`default_nettype none

package farg_pkg;

    // Fixed design constants.
    localparam int unsigned POLE_PAIRS = 4;
    localparam int unsigned HOLD_TICKS = 1000;
    localparam int unsigned IDLE_TICKS = 1000;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 8;

    // Operating modes.
    localparam logic [4:0] MODE_ZERO_ELEC = 5'd1;
    localparam logic [4:0] MODE_FORCE_A   = 5'd8;
    localparam logic [4:0] MODE_FORCE_B   = 5'd9;   // forced, but no current drive flag
    localparam logic [4:0] MODE_FORCE_C   = 5'd10;
    localparam logic [4:0] MODE_PROFILE   = 5'd19;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RUN_MODE           = 8'd0,
        REG_ID_RAMP_TICKS      = 8'd1,
        REG_ID_STEP            = 8'd2,
        REG_SPEED_RAMP_TICKS   = 8'd3,
        REG_SPEED_STEP         = 8'd4,
        REG_PROFILE_RAMP_TICKS = 8'd5,
        REG_PROFILE_STEP       = 8'd6,
        REG_ANGLE_OFFSET       = 8'd7
    } t_reg_index;

    typedef struct packed {
        logic [15:0]        mech_angle;
        logic [11:0]        elec_angle;
        logic signed [23:0] current_ref;
        logic               current_ref_drive;
        logic signed [23:0] speed_now;
    } t_result;

    // Saturate a widened signed sum to 24-bit signed.
    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v > 26'sd8388607) begin
            r = 24'sh7fffff;
        end else if (v < -26'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/forced_angle_ramp_generator.sv =====
`default_nettype none

// Forced-angle start-up generator. Each accepted word is one control tick: in modes 8, 9,
// 10 and 19 with ready set it ramps the d-current reference, latches the measured angle
// once, then integrates a ramped (or, in mode 19, up/hold/down/idle profiled) speed into
// the angle; else the measured angle passes through. A word is taken each clock while
// o_in_stall is low and registered into the output word, or the skid entry if that is
// stalled; the tick update is one pass of adders and comparators on the state registers.
// A two-entry output buffer lets the next word enter while a result is stalled. The user
// must write configuration registers only while no word is in flight (not enforced).
module forced_angle_ramp_generator
    import farg_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire [15:0]             i_measured_angle,
    input  wire                    i_ready_req,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic [15:0]            o_mech_angle,
    output logic [11:0]            o_elec_angle,
    output logic signed [23:0]     o_current_ref,
    output logic                   o_current_ref_drive,
    output logic signed [23:0]     o_speed_now
);

    // Configuration.
    logic [4:0]         r_run_mode;
    logic [15:0]        r_id_ramp_ticks;
    logic signed [15:0] r_id_step;
    logic [15:0]        r_speed_ramp_ticks;
    logic signed [15:0] r_speed_step;
    logic [15:0]        r_profile_ramp_ticks;
    logic signed [15:0] r_profile_step;
    logic [15:0]        r_angle_offset;

    // Tick state.
    logic [16:0]        r_id_cnt,     n_id_cnt;
    logic signed [23:0] r_id_cur,     n_id_cur;
    logic [16:0]        r_spd_cnt,    n_spd_cnt;
    logic signed [23:0] r_spd_val,    n_spd_val;
    logic               r_unlatched,  n_unlatched;
    logic [23:0]        r_accum,      n_accum;
    logic [18:0]        r_prof_cnt,   n_prof_cnt;
    logic signed [23:0] r_prof_spd,   n_prof_spd;
    logic               r_prof_neg,   n_prof_neg;
    logic signed [23:0] r_applied,    n_applied;

    // Output buffer.
    t_result r_out, r_skid, n_res;
    logic    r_out_v, r_skid_v;

    logic in_fire, out_fire, forced, act, id_run, integ, spd_run;
    logic signed [16:0] prof_step_ext, prof_step;
    logic [18:0] up_end, hold_end, down_end, cycle_end, prof_c;
    logic [23:0] accum_base;
    logic signed [25:0] accum_sum;
    logic [15:0] mech, rel;
    logic [20:0] pole_prod;

    assign o_in_stall = r_skid_v;
    assign in_fire    = i_in_valid && !r_skid_v;
    assign out_fire   = r_out_v && !i_out_stall;

    assign forced = (r_run_mode == MODE_FORCE_A) || (r_run_mode == MODE_FORCE_B) ||
                    (r_run_mode == MODE_FORCE_C) || (r_run_mode == MODE_PROFILE);
    assign act    = forced && i_ready_req;

    assign prof_step_ext = 17'(r_profile_step);
    assign up_end    = 19'(r_profile_ramp_ticks);
    assign hold_end  = up_end + 19'(HOLD_TICKS);
    assign down_end  = 19'({r_profile_ramp_ticks, 1'b0}) + 19'(HOLD_TICKS);
    assign cycle_end = down_end + 19'(IDLE_TICKS);
    assign prof_c    = r_prof_cnt + 19'd1;

    always_comb begin
        n_id_cnt    = r_id_cnt;
        n_id_cur    = r_id_cur;
        n_spd_cnt   = r_spd_cnt;
        n_spd_val   = r_spd_val;
        n_unlatched = r_unlatched;
        n_accum     = r_accum;
        n_prof_cnt  = r_prof_cnt;
        n_prof_spd  = r_prof_spd;
        n_prof_neg  = r_prof_neg;
        n_applied   = r_applied;
        prof_step   = r_prof_neg ? -prof_step_ext : prof_step_ext;
        accum_base  = r_unlatched ? {i_measured_angle, 8'h00} : r_accum;
        accum_sum   = '0;
        spd_run     = 1'b0;

        id_run = r_id_cnt <= 17'(r_id_ramp_ticks);
        if (id_run) begin
            n_id_cur = sat24(26'(r_id_cur) + 26'(r_id_step));
            n_id_cnt = r_id_cnt + 17'd1;
        end
        n_unlatched = 1'b0;
        n_accum     = accum_base;
        integ       = n_id_cnt > 17'(r_id_ramp_ticks);

        if (integ) begin
            if (r_run_mode != MODE_PROFILE) begin
                spd_run = r_spd_cnt <= 17'(r_speed_ramp_ticks);
                if (spd_run) begin
                    n_spd_val = sat24(26'(r_spd_val) + 26'(r_speed_step));
                    n_spd_cnt = r_spd_cnt + 17'd1;
                    n_applied = n_spd_val;
                end
            end else begin
                n_prof_cnt = prof_c;
                if (prof_c <= up_end) begin
                    n_prof_spd = sat24(26'(r_prof_spd) + 26'(prof_step));
                end else if (prof_c > hold_end && prof_c <= down_end) begin
                    n_prof_spd = sat24(26'(r_prof_spd) - 26'(prof_step));
                end else if (prof_c > down_end && prof_c < cycle_end) begin
                    n_prof_spd = '0;
                end
                if (prof_c == cycle_end) begin
                    n_prof_cnt = '0;
                    n_prof_neg = !r_prof_neg;
                end
                n_applied = n_prof_spd;
            end
            // Wrap one turn above, clamp to zero below.
            accum_sum = $signed({2'b00, accum_base}) + 26'(n_applied);
            if (accum_sum >= 26'sd16777216) begin
                accum_sum = accum_sum - 26'sd16777216;
            end
            if (accum_sum < 26'sd0) begin
                accum_sum = '0;
            end
            n_accum = accum_sum[23:0];
        end

        mech      = act ? n_accum[23:8] : i_measured_angle;
        rel       = mech - r_angle_offset;
        pole_prod = {5'd0, rel} * 21'(POLE_PAIRS);

        n_res.mech_angle        = rel;
        n_res.elec_angle        = (r_run_mode == MODE_ZERO_ELEC) ? 12'd0 : pole_prod[15:4];
        n_res.current_ref       = act ? n_id_cur : r_id_cur;
        n_res.current_ref_drive = act && id_run && (r_run_mode != MODE_FORCE_B);
        n_res.speed_now         = (act && integ) ? n_applied : 24'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_mode           <= '0;
            r_id_ramp_ticks      <= '0;
            r_id_step            <= '0;
            r_speed_ramp_ticks   <= '0;
            r_speed_step         <= '0;
            r_profile_ramp_ticks <= '0;
            r_profile_step       <= '0;
            r_angle_offset       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RUN_MODE:           r_run_mode           <= i_cfg_data[4:0];
                REG_ID_RAMP_TICKS:      r_id_ramp_ticks      <= i_cfg_data;
                REG_ID_STEP:            r_id_step            <= i_cfg_data;
                REG_SPEED_RAMP_TICKS:   r_speed_ramp_ticks   <= i_cfg_data;
                REG_SPEED_STEP:         r_speed_step         <= i_cfg_data;
                REG_PROFILE_RAMP_TICKS: r_profile_ramp_ticks <= i_cfg_data;
                REG_PROFILE_STEP:       r_profile_step       <= i_cfg_data;
                REG_ANGLE_OFFSET:       r_angle_offset       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_cnt    <= '0;
            r_id_cur    <= '0;
            r_spd_cnt   <= '0;
            r_spd_val   <= '0;
            r_unlatched <= 1'b1;
            r_accum     <= '0;
            r_prof_cnt  <= '0;
            r_prof_spd  <= '0;
            r_prof_neg  <= 1'b0;
            r_applied   <= '0;
        end else if (in_fire && act) begin
            r_id_cnt    <= n_id_cnt;
            r_id_cur    <= n_id_cur;
            r_spd_cnt   <= n_spd_cnt;
            r_spd_val   <= n_spd_val;
            r_unlatched <= n_unlatched;
            r_accum     <= n_accum;
            r_prof_cnt  <= n_prof_cnt;
            r_prof_spd  <= n_prof_spd;
            r_prof_neg  <= n_prof_neg;
            r_applied   <= n_applied;
        end
    end

    // The skid entry fills only when a new word arrives while the output word is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_fire || !r_out_v) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= in_fire;
                if (in_fire) begin
                    r_out <= n_res;
                end
            end
        end else if (in_fire) begin
            r_skid   <= n_res;
            r_skid_v <= 1'b1;
        end
    end

    assign o_out_valid         = r_out_v;
    assign o_mech_angle        = r_out.mech_angle;
    assign o_elec_angle        = r_out.elec_angle;
    assign o_current_ref       = r_out.current_ref;
    assign o_current_ref_drive = r_out.current_ref_drive;
    assign o_speed_now         = r_out.speed_now;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output word");

    a_id_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id_cnt <= 17'd65536)
        else $error("current ramp counter ran past its limit");

    a_spd_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spd_cnt <= 17'd65536)
        else $error("speed ramp counter ran past its limit");

    a_latch_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_unlatched) |-> $past(in_fire && act))
        else $error("angle latched without a forced tick");

endmodule

`default_nettype wire
